### hw/rtl/pps_pkg.sv
`default_nettype none
package pps_pkg;

	localparam int DEF_MAX_SLOTS = 16;

	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
	localparam logic [STEP_W-1:0] STEP_DECODE = 3'd1;
	localparam logic [STEP_W-1:0] STEP_SCAN   = 3'd2;
	localparam logic [STEP_W-1:0] STEP_DRAIN  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_TAT    = 3'd4;
	localparam logic [STEP_W-1:0] STEP_WT     = 3'd5;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd6;
	localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd7;

	// jump taken when the condition holds, else fall through to step + 1
	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_NO_START,
		COND_IS_LOAD,
		COND_SCAN_MORE
	} cond_t;

	typedef struct packed {
		logic              capture;
		logic              clr_scan;
		logic              rd_scan;
		logic              load_wr;
		logic              dec_wr;
		logic              calc_tat;
		logic              calc_wt;
		logic              emit;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic is_load;
		logic scan_more;
	} status_t;

	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] remain;
		logic [7:0]  prio;
	} entry_t;

	function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = '0;
		case (step)
			STEP_IDLE: begin
				c.capture  = 1'b1;
				c.clr_scan = 1'b1;
				c.cond     = COND_NO_START;
				c.target   = STEP_IDLE;
			end
			STEP_DECODE: begin
				c.cond   = COND_IS_LOAD;
				c.target = STEP_LOAD;
			end
			STEP_SCAN: begin
				c.rd_scan = 1'b1;
				c.cond    = COND_SCAN_MORE;
				c.target  = STEP_SCAN;
			end
			STEP_DRAIN: begin
				c.cond = COND_NEXT;
			end
			STEP_TAT: begin
				c.dec_wr   = 1'b1;
				c.calc_tat = 1'b1;
				c.cond     = COND_NEXT;
			end
			STEP_WT: begin
				c.calc_wt = 1'b1;
				c.cond    = COND_NEXT;
			end
			STEP_EMIT: begin
				c.emit   = 1'b1;
				c.cond   = COND_ALWAYS;
				c.target = STEP_IDLE;
			end
			STEP_LOAD: begin
				c.load_wr = 1'b1;
				c.cond    = COND_ALWAYS;
				c.target  = STEP_IDLE;
			end
			default: begin
				c.cond   = COND_ALWAYS;
				c.target = STEP_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/pps_sequencer.sv
`default_nettype none
module pps_sequencer (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  pps_pkg::status_t  status,
	output pps_pkg::ctrl_t    ctrl,
	output logic              busy
);
	import pps_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic [STEP_W-1:0] step_inc;

	assign ctrl     = ucode_rom(step_q);
	assign step_inc = step_q + STEP_W'(1);
	assign busy     = (step_q != STEP_IDLE);

	always_comb begin
		case (ctrl.cond)
			COND_NEXT:      step_d = step_inc;
			COND_ALWAYS:    step_d = ctrl.target;
			COND_NO_START:  step_d = start ? step_inc : ctrl.target;
			COND_IS_LOAD:   step_d = status.is_load ? ctrl.target : step_inc;
			COND_SCAN_MORE: step_d = status.scan_more ? ctrl.target : step_inc;
			default:        step_d = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/pps_datapath.sv
`default_nettype none
module pps_datapath #(
	parameter int MAX_SLOTS = pps_pkg::DEF_MAX_SLOTS
) (
	input  wire               clk,
	input  wire               arst_n,
	input  pps_pkg::ctrl_t    ctrl,
	input  wire               start,
	input  wire               kind,
	input  wire  [3:0]        slot,
	input  wire  [15:0]       arrival_time,
	input  wire  [15:0]       burst_time,
	input  wire  [7:0]        priority_req,
	input  wire               cfg_wen,
	input  wire  [4:0]        cfg_wdata,
	output pps_pkg::status_t  status,
	output logic              result_strobe,
	output logic              ran,
	output logic [3:0]        run_slot,
	output logic              finished,
	output logic [31:0]       waiting_time,
	output logic [31:0]       turnaround_time,
	output logic [4:0]        done_count,
	output logic              all_done,
	output logic [39:0]       total_waiting,
	output logic [39:0]       total_turnaround
);
	import pps_pkg::*;

	localparam int AW  = $clog2(MAX_SLOTS);
	localparam int CW  = $clog2(MAX_SLOTS + 1);
	localparam int LW  = (CW > 5) ? CW : 5;

	// captured input word
	logic          kind_q;
	logic [3:0]    slot_q;
	logic [15:0]   arr_q;
	logic [15:0]   burst_q;
	logic [7:0]    prio_q;

	logic [4:0]    pc_q;
	logic [LW-1:0] pc_ext;
	logic [LW-1:0] lim;
	logic [LW-1:0] idx_q;
	logic          rd_en;

	entry_t        mem [MAX_SLOTS];
	entry_t        rd_s1;
	logic          rd_valid_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          slot_ok;

	logic          found_q;
	entry_t        best_q;
	logic [AW-1:0] best_idx_q;
	logic          elig;
	logic          take;

	logic          fin_q;
	logic [31:0]   tat_q;
	logic [31:0]   wt_q;
	logic [31:0]   time_q;
	logic [4:0]    completed_q;
	logic [4:0]    completed_d;
	logic [39:0]   wsum_q;
	logic [39:0]   tsum_q;

	logic          strobe_q;
	logic          ran_q;
	logic [3:0]    run_slot_q;
	logic          finished_q;
	logic [31:0]   waiting_q;
	logic [31:0]   turnaround_q;
	logic          all_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= 1'b0;
		end else if (ctrl.capture && start) begin
			kind_q <= kind;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture && start) begin
			slot_q  <= slot;
			arr_q   <= arrival_time;
			burst_q <= burst_time;
			prio_q  <= priority_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 5'd1;
		end else if (cfg_wen) begin
			pc_q <= cfg_wdata;
		end
	end

	// slots scanned: process count clamped to the store depth
	assign pc_ext = LW'(pc_q);
	assign lim    = (pc_ext > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : pc_ext;
	assign rd_en  = ctrl.rd_scan && (idx_q < lim);

	assign status.is_load   = !kind_q;
	assign status.scan_more = ((LW + 1)'(idx_q) + (LW + 1)'(1)) < (LW + 1)'(lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (ctrl.clr_scan) begin
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + LW'(1);
			end
		end
	end

	assign slot_ok = (32'(slot_q) < MAX_SLOTS);
	assign wr_en   = (ctrl.load_wr && slot_ok) || (ctrl.dec_wr && found_q);
	assign wr_addr = ctrl.load_wr ? AW'(slot_q) : best_idx_q;

	always_comb begin
		if (ctrl.load_wr) begin
			wr_data.arrival = arr_q;
			wr_data.burst   = burst_q;
			wr_data.remain  = burst_q;
			wr_data.prio    = prio_q;
		end else begin
			wr_data        = best_q;
			wr_data.remain = best_q.remain - 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1     <= mem[idx_q[AW-1:0]];
			rd_idx_s1 <= idx_q[AW-1:0];
		end
	end

	// strict less-than keeps the lower slot on a tie
	assign elig = rd_valid_s1 && (rd_s1.remain != 16'd0) && (32'(rd_s1.arrival) <= time_q);
	assign take = elig && (!found_q || (rd_s1.prio < best_q.prio));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clr_scan) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q     <= rd_s1;
			best_idx_q <= rd_idx_s1;
		end
		if (ctrl.calc_tat) begin
			tat_q <= time_q + 32'd1 - 32'(best_q.arrival);
		end
		if (ctrl.calc_wt) begin
			wt_q <= tat_q - 32'(best_q.burst);
		end
		if (ctrl.emit) begin
			ran_q        <= found_q;
			run_slot_q   <= found_q ? 4'(best_idx_q) : 4'd0;
			finished_q   <= fin_q;
			waiting_q    <= fin_q ? wt_q : 32'd0;
			turnaround_q <= fin_q ? tat_q : 32'd0;
			all_done_q   <= (completed_d == pc_q);
		end
	end

	assign completed_d = (fin_q && (completed_q != 5'd31)) ? completed_q + 5'd1 : completed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q       <= 1'b0;
			time_q      <= '0;
			completed_q <= '0;
			wsum_q      <= '0;
			tsum_q      <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= ctrl.emit;
			if (ctrl.calc_tat) begin
				fin_q <= found_q && (best_q.remain == 16'd1);
			end
			if (ctrl.emit) begin
				time_q      <= time_q + 32'd1;
				completed_q <= completed_d;
				if (fin_q) begin
					wsum_q <= wsum_q + 40'(wt_q);
					tsum_q <= tsum_q + 40'(tat_q);
				end
			end
		end
	end

	assign result_strobe    = strobe_q;
	assign ran              = ran_q;
	assign run_slot         = run_slot_q;
	assign finished         = finished_q;
	assign waiting_time     = waiting_q;
	assign turnaround_time  = turnaround_q;
	assign done_count       = completed_q;
	assign all_done         = all_done_q;
	assign total_waiting    = wsum_q;
	assign total_turnaround = tsum_q;

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |=> !strobe_q)
		else $error("result strobe held for two cycles");

	a_fin_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && finished_q |-> ran_q)
		else $error("completion reported on an idle tick");

	a_count_only_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.emit |=> $stable(completed_q))
		else $error("completion count moved outside emit step");

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(ctrl.rd_scan))
		else $error("compare stage fed without a scan read");

endmodule
`default_nettype wire

### hw/rtl/preemptive_priority_scheduler_core.sv
// Load word: busy in DECODE and LOAD after acceptance, no result.
// Tick busy: DECODE, max(1, min(process_count, MAX_SLOTS)) SCANs, DRAIN to EMIT;
// the result strobe fires on the cycle after, start may be taken in that same cycle.
// Throughput set by the scan: one slot per cycle through the slot memory read port.
// Results cannot be stalled: each is on the ports for the single strobe cycle.
// Async reset clears time, completion count, totals; process_count resets to 1.
`default_nettype none
module preemptive_priority_scheduler_core #(
	parameter int MAX_SLOTS = pps_pkg::DEF_MAX_SLOTS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         kind,
	input  wire  [3:0]  slot,
	input  wire  [15:0] arrival_time,
	input  wire  [15:0] burst_time,
	input  wire  [7:0]  priority_req,
	input  wire         cfg_wen,
	input  wire  [4:0]  cfg_wdata,
	output logic        result_strobe,
	output logic        ran,
	output logic [3:0]  run_slot,
	output logic        finished,
	output logic [31:0] waiting_time,
	output logic [31:0] turnaround_time,
	output logic [4:0]  done_count,
	output logic        all_done,
	output logic [39:0] total_waiting,
	output logic [39:0] total_turnaround
);
	import pps_pkg::*;

	ctrl_t   ctrl;
	status_t status;

	pps_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	pps_datapath #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.start            (start),
		.kind             (kind),
		.slot             (slot),
		.arrival_time     (arrival_time),
		.burst_time       (burst_time),
		.priority_req     (priority_req),
		.cfg_wen          (cfg_wen),
		.cfg_wdata        (cfg_wdata),
		.status           (status),
		.result_strobe    (result_strobe),
		.ran              (ran),
		.run_slot         (run_slot),
		.finished         (finished),
		.waiting_time     (waiting_time),
		.turnaround_time  (turnaround_time),
		.done_count       (done_count),
		.all_done         (all_done),
		.total_waiting    (total_waiting),
		.total_turnaround (total_turnaround)
	);

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
module testbench;

	localparam int   SLOTS          = pps_pkg::DEF_MAX_SLOTS;
	localparam logic KIND_LOAD      = 1'b0;
	localparam logic KIND_TICK      = 1'b1;
	localparam int   WATCHDOG_LIMIT = 2000;
	localparam int   RAND_PHASES    = 10;
	localparam int   WORDS_PER_PHASE = 158;
	localparam int   DIR_ROWS       = 20;

	typedef enum logic {ROW_CFG, ROW_WORD} row_act_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  slot;
		logic [15:0] arrival_time;
		logic [15:0] burst_time;
		logic [7:0]  priority_req;
	} sched_word_t;

	typedef struct packed {
		logic        ran;
		logic [3:0]  run_slot;
		logic        finished;
		logic [31:0] waiting_time;
		logic [31:0] turnaround_time;
		logic [4:0]  done_count;
		logic        all_done;
		logic [39:0] total_waiting;
		logic [39:0] total_turnaround;
	} tick_report_t;

	typedef struct packed {
		row_act_t     act;
		logic [4:0]   count;
		sched_word_t  w;
		logic         typed;
		tick_report_t rep;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        kind;
	logic [3:0]  slot;
	logic [15:0] arrival_time;
	logic [15:0] burst_time;
	logic [7:0]  priority_req;
	logic        cfg_wen;
	logic [4:0]  cfg_wdata;
	logic        result_strobe;
	logic        ran;
	logic [3:0]  run_slot;
	logic        finished;
	logic [31:0] waiting_time;
	logic [31:0] turnaround_time;
	logic [4:0]  done_count;
	logic        all_done;
	logic [39:0] total_waiting;
	logic [39:0] total_turnaround;

	// scheduler shadow state
	logic [15:0] arr_q [SLOTS];
	logic [15:0] bst_q [SLOTS];
	logic [15:0] rem_q [SLOTS];
	logic [7:0]  pri_q [SLOTS];
	bit          loaded_q [SLOTS];
	logic [31:0] now_t;
	logic [4:0]  n_done;
	logic [39:0] sum_wait;
	logic [39:0] sum_tat;
	logic [4:0]  proc_cnt;

	tick_report_t reports_due [$];
	tick_report_t want;
	dir_row_t     dir_tab [DIR_ROWS];
	int           error_count = 0;
	int           quiet_cycles = 0;

	preemptive_priority_scheduler_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.kind             (kind),
		.slot             (slot),
		.arrival_time     (arrival_time),
		.burst_time       (burst_time),
		.priority_req     (priority_req),
		.cfg_wen          (cfg_wen),
		.cfg_wdata        (cfg_wdata),
		.result_strobe    (result_strobe),
		.ran              (ran),
		.run_slot         (run_slot),
		.finished         (finished),
		.waiting_time     (waiting_time),
		.turnaround_time  (turnaround_time),
		.done_count       (done_count),
		.all_done         (all_done),
		.total_waiting    (total_waiting),
		.total_turnaround (total_turnaround)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void load_slot(input sched_word_t w);
		arr_q[w.slot]    = w.arrival_time;
		bst_q[w.slot]    = w.burst_time;
		rem_q[w.slot]    = w.burst_time;
		pri_q[w.slot]    = w.priority_req;
		loaded_q[w.slot] = 1'b1;
	endfunction

	function automatic tick_report_t schedule_tick();
		tick_report_t r;
		int           lim;
		int           pick;
		bit           found;
		logic [31:0]  tat;
		logic [31:0]  wt;
		r     = '0;
		lim   = (proc_cnt > SLOTS) ? SLOTS : proc_cnt;
		pick  = 0;
		found = 1'b0;
		for (int i = 0; i < lim; i++) begin
			if (rem_q[i] != 16'd0 && {16'd0, arr_q[i]} <= now_t) begin
				if (!found || pri_q[i] < pri_q[pick]) begin
					pick  = i;
					found = 1'b1;
				end
			end
		end
		if (found) begin
			r.ran      = 1'b1;
			r.run_slot = 4'(pick);
			rem_q[pick] = rem_q[pick] - 16'd1;
			if (rem_q[pick] == 16'd0) begin
				tat = now_t + 32'd1 - {16'd0, arr_q[pick]};
				wt  = tat - {16'd0, bst_q[pick]};
				r.finished        = 1'b1;
				r.turnaround_time = tat;
				r.waiting_time    = wt;
				if (n_done < 5'd31)
					n_done = n_done + 5'd1;
				sum_wait = sum_wait + {8'd0, wt};
				sum_tat  = sum_tat + {8'd0, tat};
			end
		end
		now_t = now_t + 32'd1;
		r.done_count       = n_done;
		r.all_done         = (n_done == proc_cnt);
		r.total_waiting    = sum_wait;
		r.total_turnaround = sum_tat;
		return r;
	endfunction

	// loads mostly near the current time with short bursts and clustered priorities;
	// a tick that would scan a never-loaded slot becomes a load of that slot
	function automatic sched_word_t make_word();
		sched_word_t w;
		int          lim;
		int          hole;
		int          roll;
		int          r;
		lim  = (proc_cnt > SLOTS) ? SLOTS : proc_cnt;
		hole = -1;
		for (int i = lim - 1; i >= 0; i--)
			if (!loaded_q[i])
				hole = i;
		roll = $urandom_range(0, 99);
		w.slot         = 4'($urandom);
		w.arrival_time = 16'($urandom);
		w.burst_time   = 16'($urandom);
		w.priority_req = 8'($urandom);
		if (roll < 55 && hole < 0) begin
			w.kind = KIND_TICK;
			return w;
		end
		w.kind = KIND_LOAD;
		if (roll < 55)
			w.slot = 4'(hole);
		else if (lim > 0 && $urandom_range(0, 99) < 85)
			w.slot = 4'($urandom_range(0, lim - 1));
		r = $urandom_range(0, 9);
		if (r < 7)
			w.arrival_time = now_t[15:0] + 16'($urandom_range(0, 12)) - 16'd4;
		else if (r == 9)
			w.arrival_time = 16'd0;
		r = $urandom_range(0, 99);
		if (r < 80)
			w.burst_time = 16'($urandom_range(1, 8));
		else if (r < 88)
			w.burst_time = 16'd0;
		else if (r >= 95)
			w.burst_time = 16'($urandom_range(9, 40));
		if ($urandom_range(0, 9) < 6)
			w.priority_req = 8'($urandom_range(0, 7));
		return w;
	endfunction

	task automatic send_word(input sched_word_t w, input int gap, input bit typed,
			input tick_report_t rep);
		tick_report_t predicted;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start        <= 1'b1;
		kind         <= w.kind;
		slot         <= w.slot;
		arrival_time <= w.arrival_time;
		burst_time   <= w.burst_time;
		priority_req <= w.priority_req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (w.kind == KIND_LOAD)
			load_slot(w);
		else begin
			predicted = schedule_tick();
			reports_due.push_back(typed ? rep : predicted);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_count(input logic [4:0] v);
		drain_results();
		// a load may still be in flight after the last report
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
		proc_cnt = v;
	endtask

	task automatic check_field(input string name, input logic [39:0] exp_v,
			input logic [39:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (reports_due.size() == 0) begin
				$error("report word with no tick outstanding");
				error_count++;
			end else begin
				want = reports_due.pop_front();
				check_field("ran", 40'(want.ran), 40'(ran));
				check_field("run_slot", 40'(want.run_slot), 40'(run_slot));
				check_field("finished", 40'(want.finished), 40'(finished));
				check_field("waiting_time", 40'(want.waiting_time), 40'(waiting_time));
				check_field("turnaround_time", 40'(want.turnaround_time),
					40'(turnaround_time));
				check_field("done_count", 40'(want.done_count), 40'(done_count));
				check_field("all_done", 40'(want.all_done), 40'(all_done));
				check_field("total_waiting", want.total_waiting, total_waiting);
				check_field("total_turnaround", want.total_turnaround, total_turnaround);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_strobe)
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int         idle_mode;
		int         gap;
		logic [4:0] cnt;
		arst_n       = 1'b0;
		start        = 1'b0;
		kind         = KIND_LOAD;
		slot         = 4'd0;
		arrival_time = 16'd0;
		burst_time   = 16'd0;
		priority_req = 8'd0;
		cfg_wen      = 1'b0;
		cfg_wdata    = 5'd0;
		for (int i = 0; i < SLOTS; i++) begin
			arr_q[i]    = '0;
			bst_q[i]    = '0;
			rem_q[i]    = '0;
			pri_q[i]    = '0;
			loaded_q[i] = 1'b0;
		end
		now_t    = '0;
		n_done   = '0;
		sum_wait = '0;
		sum_tat  = '0;
		proc_cnt = 5'd1;

		dir_tab = '{
			'{ROW_CFG,  5'd0, '0, 1'b0, '0},
			// no slots scheduled: idle, and zero completions already count as all done
			'{ROW_WORD, 5'd0, '{KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
				'{1'b0, 4'd0, 1'b0, 32'd0, 32'd0, 5'd0, 1'b1, 40'd0, 40'd0}},
			'{ROW_CFG,  5'd1, '0, 1'b0, '0},
			'{ROW_WORD, 5'd0, '{KIND_LOAD, 4'd0, 16'd0, 16'd1, 8'd255}, 1'b0, '0},
			// runs at time 1, done at 2
			'{ROW_WORD, 5'd0, '{KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
				'{1'b1, 4'd0, 1'b1, 32'd1, 32'd2, 5'd1, 1'b1, 40'd1, 40'd2}},
			'{ROW_WORD, 5'd0, '{KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
				'{1'b0, 4'd0, 1'b0, 32'd0, 32'd0, 5'd1, 1'b1, 40'd1, 40'd2}},
			'{ROW_CFG,  5'd3, '0, 1'b0, '0},
			'{ROW_WORD, 5'd0, '{KIND_LOAD, 4'd1, 16'hFFFF, 16'hFFFF, 8'd0}, 1'b0, '0},
			'{ROW_WORD, 5'd0, '{KIND_LOAD, 4'd2, 16'd0, 16'd2, 8'd7}, 1'b0, '0},
			'{ROW_WORD, 5'd0, '{KIND_LOAD, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
			'{ROW_WORD, 5'd0, '{KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
			// same priority as slot 2: lower index wins
			'{ROW_WORD, 5'd0, '{KIND_LOAD, 4'd0, 16'd4, 16'd3, 8'd7}, 1'b0, '0},
			'{ROW_WORD, 5'd0, '{KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
			'{ROW_WORD, 5'd0, '{KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
			// reload mid-run
			'{ROW_WORD, 5'd0, '{KIND_LOAD, 4'd0, 16'd0, 16'd1, 8'd200}, 1'b0, '0},
			'{ROW_WORD, 5'd0, '{KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
			'{ROW_WORD, 5'd0, '{KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
			'{ROW_WORD, 5'd0, '{KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b0, '0},
			'{ROW_WORD, 5'd0, '{KIND_LOAD, 4'd15, 16'h5AA5, 16'hA55A, 8'hAA}, 1'b0, '0},
			'{ROW_CFG,  5'd31, '0, 1'b0, '0}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].act == ROW_CFG)
				write_count(dir_tab[i].count);
			else
				send_word(dir_tab[i].w, $urandom_range(0, 5), dir_tab[i].typed,
					dir_tab[i].rep);
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: cnt = 5'd16;
				1: cnt = 5'd4;
				2: cnt = 5'd31;
				3: cnt = 5'd0;
				4: cnt = 5'd1;
				5: cnt = 5'($urandom_range(2, 15));
				6: cnt = 5'd16;
				7: cnt = 5'($urandom_range(17, 30));
				8: cnt = 5'd8;
				default: cnt = 5'd2;
			endcase
			write_count(cnt);
			idle_mode = $urandom_range(0, 2);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				gap = (idle_mode == 0) ? 0 : $urandom_range(0, 5);
				send_word(make_word(), gap, 1'b0, '0);
				if ($urandom_range(0, 99) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (30) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
